// ===== design/sbpg_pkg.sv =====
package sbpg_pkg;

	localparam int unsigned BAG_SIZE_DEF = 7;
	localparam int unsigned SEED_W = 32;
	localparam int unsigned PIECE_W = 3;
	localparam int unsigned CMD_W = 2;

	localparam logic [SEED_W-1:0] LCG_MUL = 32'd1664525;
	localparam logic [SEED_W-1:0] LCG_ADD = 32'd1013904223;

	// remainder unit consumes this many seed bits per cycle
	localparam int unsigned MOD_CHUNK_W = 8;
	localparam int unsigned NUM_CHUNKS = SEED_W / MOD_CHUNK_W;
	localparam int unsigned CHUNK_CNT_W = $clog2(NUM_CHUNKS);

	localparam logic [CMD_W-1:0] CMD_DRAW = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET_SEED = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

	typedef struct packed {
		logic load_seed;
		logic fill_start;
		logic fill_write;
		logic seed_step;
		logic mod_step;
		logic swap_read;
		logic swap_wr_a;
		logic swap_wr_b;
		logic draw_read;
		logic draw_out;
	} sbpg_cmd_t;

	typedef struct packed {
		logic bag_empty;
		logic fill_last;
		logic mod_last;
		logic shuffle_last;
	} sbpg_stat_t;

endpackage

// ===== design/shuffled_bag_piece_generator_core.sv =====
// Shuffled bag generator: keeps an LCG seed and a bag of BAG_SIZE symbols.
// A word is taken when start is high while busy is low; set seed finishes
// in that cycle. A draw from a bag that still holds symbols passes through a
// read state and an output state, and its piece appears with done, high for
// one cycle, as busy falls; the receiver cannot stall, so piece must be captured on the done cycle.
// A draw that finds the bag empty, and a restart, first refill the bag
// and shuffle it with (BAG_SIZE-1) steps, each made of one seed update
// through the multiplier, the remainder unit at 8 seed bits per cycle over
// the whole seed, and a read and two writes, the writes on the single write
// port of the bag memory. Command code 3 is taken and ignored.
module shuffled_bag_piece_generator_core #(
	parameter int unsigned BAG_SIZE = sbpg_pkg::BAG_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [sbpg_pkg::CMD_W-1:0]    command,
	input  logic [sbpg_pkg::SEED_W-1:0]   seed_value,
	output logic [sbpg_pkg::PIECE_W-1:0]  piece,
	output logic                          done
);
	import sbpg_pkg::*;

	sbpg_cmd_t  cmd;
	sbpg_stat_t stat;

	sbpg_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.busy    (busy),
		.cmd     (cmd),
		.stat    (stat)
	);

	sbpg_dp #(
		.BAG_SIZE (BAG_SIZE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.seed_value (seed_value),
		.piece      (piece),
		.done       (done)
	);

endmodule

// ===== design/sbpg_dp.sv =====
module sbpg_dp #(
	parameter int unsigned BAG_SIZE = sbpg_pkg::BAG_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sbpg_pkg::sbpg_cmd_t           cmd,
	output sbpg_pkg::sbpg_stat_t          stat,
	input  logic [sbpg_pkg::SEED_W-1:0]   seed_value,
	output logic [sbpg_pkg::PIECE_W-1:0]  piece,
	output logic                          done
);
	import sbpg_pkg::*;

	localparam int unsigned IW = $clog2(BAG_SIZE);
	localparam int unsigned PW = $clog2(BAG_SIZE + 1);

	logic [SEED_W-1:0]      seed_q;
	logic [SEED_W-1:0]      next_seed;
	logic [SEED_W-1:0]      mod_sh_q;
	logic [CHUNK_CNT_W-1:0] chunk_q;
	logic [IW-1:0]          rem_q;
	logic [IW-1:0]          rem_nxt;
	logic [IW:0]            modulus;
	logic [IW-1:0]          idx_q;
	logic [PW-1:0]          pos_q;
	logic [IW-1:0]          addr_a;
	logic [IW-1:0]          rd_a_q;
	logic [IW-1:0]          rd_b_q;
	logic [IW-1:0]          bag_mem [BAG_SIZE];
	logic [PIECE_W-1:0]     piece_q;
	logic                   done_q;

	assign next_seed = seed_q * LCG_MUL + LCG_ADD;
	assign modulus = (IW+1)'(idx_q) + (IW+1)'(1);
	assign addr_a = cmd.draw_read ? pos_q[IW-1:0] : idx_q;

	assign stat.bag_empty = (pos_q >= PW'(BAG_SIZE));
	assign stat.fill_last = (idx_q == IW'(BAG_SIZE - 1));
	assign stat.mod_last = (chunk_q == CHUNK_CNT_W'(NUM_CHUNKS - 1));
	assign stat.shuffle_last = (idx_q == IW'(1));

	// restoring remainder, msb first, one chunk of seed bits per cycle
	always_comb begin
		logic [IW:0]   t;
		logic [IW-1:0] r;
		r = rem_q;
		for (int b = 0; b < MOD_CHUNK_W; b++) begin
			t = {r, mod_sh_q[SEED_W-1-b]};
			if (t >= modulus) begin
				t = t - modulus;
			end
			r = t[IW-1:0];
		end
		rem_nxt = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			pos_q <= PW'(BAG_SIZE);
			done_q <= 1'b0;
		end else begin
			if (cmd.load_seed) begin
				seed_q <= seed_value;
			end else if (cmd.seed_step) begin
				seed_q <= next_seed;
			end
			if (cmd.fill_start) begin
				pos_q <= '0;
			end else if (cmd.draw_read) begin
				pos_q <= pos_q + PW'(1);
			end
			done_q <= cmd.draw_out;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill_start) begin
			idx_q <= '0;
		end else if (cmd.fill_write && !stat.fill_last) begin
			idx_q <= idx_q + IW'(1);
		end else if (cmd.swap_wr_b) begin
			idx_q <= idx_q - IW'(1);
		end
		if (cmd.seed_step) begin
			mod_sh_q <= next_seed;
			rem_q <= '0;
			chunk_q <= '0;
		end else if (cmd.mod_step) begin
			mod_sh_q <= mod_sh_q << MOD_CHUNK_W;
			rem_q <= rem_nxt;
			chunk_q <= chunk_q + CHUNK_CNT_W'(1);
		end
		if (cmd.draw_out) begin
			piece_q <= PIECE_W'(rd_a_q);
		end
	end

	// bag storage, one write port and two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.fill_write) begin
			bag_mem[idx_q] <= idx_q;
		end else if (cmd.swap_wr_a) begin
			bag_mem[idx_q] <= rd_b_q;
		end else if (cmd.swap_wr_b) begin
			bag_mem[rem_q] <= rd_a_q;
		end
		if (cmd.swap_read || cmd.draw_read) begin
			rd_a_q <= bag_mem[addr_a];
		end
		if (cmd.swap_read) begin
			rd_b_q <= bag_mem[rem_q];
		end
	end

	assign piece = piece_q;
	assign done = done_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held longer than one cycle");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(BAG_SIZE))
		else $error("draw position beyond bag");

	a_draw_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.draw_read |-> !stat.bag_empty)
		else $error("draw read from empty bag");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.swap_read |-> (rem_q <= idx_q))
		else $error("swap index not below modulus");

endmodule

// ===== design/sbpg_ctrl.sv =====
module sbpg_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sbpg_pkg::CMD_W-1:0]  command,
	output logic                        busy,
	output sbpg_pkg::sbpg_cmd_t         cmd,
	input  sbpg_pkg::sbpg_stat_t        stat
);
	import sbpg_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_SEED,
		ST_MOD,
		ST_SW_RD,
		ST_SW_WA,
		ST_SW_WB,
		ST_DRAW_RD,
		ST_DRAW_OUT
	} state_t;

	state_t state_q;
	logic   draw_pending_q;
	logic   accept;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load_seed = (command == CMD_SET_SEED) || (command == CMD_RESTART);
					cmd.fill_start = (command == CMD_RESTART) ||
						((command == CMD_DRAW) && stat.bag_empty);
				end
			end
			ST_FILL:     cmd.fill_write = 1'b1;
			ST_SEED:     cmd.seed_step = 1'b1;
			ST_MOD:      cmd.mod_step = 1'b1;
			ST_SW_RD:    cmd.swap_read = 1'b1;
			ST_SW_WA:    cmd.swap_wr_a = 1'b1;
			ST_SW_WB:    cmd.swap_wr_b = 1'b1;
			ST_DRAW_RD:  cmd.draw_read = 1'b1;
			ST_DRAW_OUT: cmd.draw_out = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			draw_pending_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (command == CMD_RESTART) begin
							draw_pending_q <= 1'b0;
							state_q <= ST_FILL;
						end else if (command == CMD_DRAW) begin
							draw_pending_q <= 1'b1;
							state_q <= stat.bag_empty ? ST_FILL : ST_DRAW_RD;
						end
					end
				end
				ST_FILL: begin
					if (stat.fill_last) begin
						state_q <= ST_SEED;
					end
				end
				ST_SEED: state_q <= ST_MOD;
				ST_MOD: begin
					if (stat.mod_last) begin
						state_q <= ST_SW_RD;
					end
				end
				ST_SW_RD: state_q <= ST_SW_WA;
				ST_SW_WA: state_q <= ST_SW_WB;
				ST_SW_WB: begin
					if (!stat.shuffle_last) begin
						state_q <= ST_SEED;
					end else if (draw_pending_q) begin
						state_q <= ST_DRAW_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DRAW_RD: state_q <= ST_DRAW_OUT;
				ST_DRAW_OUT: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sbpg_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [SEED_W-1:0] SEED_ONES = '1;

	class bag_scoreboard;
		logic [SEED_W-1:0] lcg_seed;
		logic [PIECE_W-1:0] bag [BAG_SIZE_DEF];
		int unsigned next_slot;
		logic [PIECE_W-1:0] expected_pieces [$];
		int unsigned mismatches;

		function new();
			lcg_seed = '0;
			next_slot = BAG_SIZE_DEF;
			mismatches = 0;
		endfunction

		task report(string what);
			mismatches++;
			$display("MISMATCH at %0t: %s", $realtime, what);
		endtask

		// refill with 0 .. size-1, then top-down swap with seed mod (i+1)
		function void reshuffle();
			logic [SEED_W-1:0] j;
			logic [PIECE_W-1:0] t;
			for (int unsigned i = 0; i < BAG_SIZE_DEF; i++)
				bag[i] = PIECE_W'(i);
			for (int unsigned i = BAG_SIZE_DEF - 1; i > 0; i--) begin
				lcg_seed = lcg_seed * LCG_MUL + LCG_ADD;
				j = lcg_seed % (i + 1);
				t = bag[i];
				bag[i] = bag[j];
				bag[j] = t;
			end
			next_slot = 0;
		endfunction

		function void note_word(logic [CMD_W-1:0] cmd, logic [SEED_W-1:0] seed);
			case (cmd)
				CMD_DRAW: begin
					if (next_slot >= BAG_SIZE_DEF)
						reshuffle();
					expected_pieces.push_back(bag[next_slot]);
					next_slot++;
				end
				CMD_SET_SEED: lcg_seed = seed;
				CMD_RESTART: begin
					lcg_seed = seed;
					reshuffle();
				end
				default: ;
			endcase
		endfunction

		task check_piece(logic [PIECE_W-1:0] got);
			logic [PIECE_W-1:0] want;
			if (expected_pieces.size() == 0) begin
				report($sformatf("piece %0d with no draw waiting", got));
			end else begin
				want = expected_pieces.pop_front();
				if (got !== want)
					report($sformatf("piece %0d, expected %0d", got, want));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [CMD_W-1:0] command = CMD_DRAW;
	logic [SEED_W-1:0] seed_value = '0;
	logic busy;
	logic [PIECE_W-1:0] piece;
	logic done;

	bag_scoreboard sb;
	bit no_idle;

	shuffled_bag_piece_generator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.seed_value(seed_value),
		.piece(piece),
		.done(done)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// words and results are both sampled here, on pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_piece(piece);
			if (start && !busy)
				sb.note_word(command, seed_value);
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (no_idle || r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(20, 4);
		return $urandom_range(120, 30);
	endfunction

	function automatic logic [SEED_W-1:0] pick_seed();
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0)
			return '0;
		if (r == 1)
			return SEED_ONES;
		return $urandom;
	endfunction

	function automatic logic [CMD_W-1:0] pick_command();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 65)
			return CMD_DRAW;
		if (r < 77)
			return CMD_SET_SEED;
		if (r < 90)
			return CMD_RESTART;
		return CMD_UNUSED;
	endfunction

	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SEED_W-1:0] seed);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		seed_value <= seed;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic send_draws(input int unsigned count);
		repeat (count) send_word(CMD_DRAW, pick_seed());
	endtask

	initial begin
		sb = new();
		no_idle = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: draws from the reset seed across a refill
		send_draws(8);
		send_word(CMD_SET_SEED, SEED_ONES);
		send_draws(2);
		send_word(CMD_UNUSED, SEED_ONES);
		send_word(CMD_RESTART, '0);
		send_draws(3);
		send_word(CMD_RESTART, SEED_ONES);
		send_draws(1);
		send_word(CMD_SET_SEED, '0);
		send_draws(6);
		send_word(CMD_UNUSED, '0);

		for (int n = 0; n < 450; n++) begin
			if (n % 40 == 0)
				no_idle = ($urandom_range(3) == 0);
			send_word(pick_command(), pick_seed());
		end
		start <= 1'b0;

		while (sb.expected_pieces.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);

		if (sb.expected_pieces.size() != 0)
			sb.report($sformatf("%0d pieces never came", sb.expected_pieces.size()));
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
